[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");
// Implication checked in the cycle after the antecedent.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`endif

[rtl/tbwp_pkg.sv]
// Package for the tile background and window pixel renderer.
// Types, constants and helper functions; no dependencies.
package tbwp_pkg;

    localparam int BankBytes    = 8192;
    localparam int PaletteBytes = 64;
    localparam int ScreenWidth  = 160;
    localparam int ScreenHeight = 144;

    localparam int VramAw = $clog2(2 * BankBytes);
    localparam int PalAw  = $clog2(PaletteBytes);

    // function codes of an input item
    localparam logic [1:0] FUNC_RENDER = 2'd0;
    localparam logic [1:0] FUNC_VRAM   = 2'd1;
    localparam logic [1:0] FUNC_PAL    = 2'd2;

    // register indexes
    localparam logic [2:0] REG_LCDC  = 3'd0;
    localparam logic [2:0] REG_SCY   = 3'd1;
    localparam logic [2:0] REG_SCX   = 3'd2;
    localparam logic [2:0] REG_WY    = 3'd3;
    localparam logic [2:0] REG_WX    = 3'd4;
    localparam logic [2:0] REG_MPAL  = 3'd5;
    localparam logic [2:0] REG_CMODE = 3'd6;

    localparam logic [12:0] MAP_LOW  = 13'h1800;
    localparam logic [12:0] MAP_HIGH = 13'h1C00;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MAP, ST_ATTR, ST_LO, ST_HI, ST_PAL, ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input item, start map fetch read for a render
        logic rd_attr;  // issue attribute read
        logic rd_lo;    // issue tile low byte read
        logic rd_hi;    // issue tile high byte read
        logic pal;      // latch colour number, read palette
        logic done;     // form result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_write;  // item is a store write or no-op
        logic quick;     // render that needs no fetch
    } t_sts;

    function automatic logic [14:0] grey(input logic [1:0] s);
        case (s)
            2'd0:    grey = 15'h7FFF;
            2'd1:    grey = 15'h56B5;
            2'd2:    grey = 15'h294A;
            default: grey = 15'h0000;
        endcase
    endfunction

endpackage

[rtl/tbwp_ctrl.sv]
// Controller state machine for the pixel renderer.
// Depends on tbwp_pkg.
module tbwp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_free,
    input  tbwp_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output tbwp_pkg::t_cmd  o_cmd
);
    tbwp_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbwp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            tbwp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tbwp_pkg::ST_MAP;
                end
            end
            tbwp_pkg::ST_MAP: begin
                if (i_sts.is_write) begin
                    n_state = tbwp_pkg::ST_IDLE;
                end else if (i_sts.quick) begin
                    n_state = tbwp_pkg::ST_OUT;
                end else begin
                    o_cmd.rd_attr = 1'b1;
                    n_state       = tbwp_pkg::ST_ATTR;
                end
            end
            tbwp_pkg::ST_ATTR: begin
                o_cmd.rd_lo = 1'b1;
                n_state     = tbwp_pkg::ST_LO;
            end
            tbwp_pkg::ST_LO: begin
                o_cmd.rd_hi = 1'b1;
                n_state     = tbwp_pkg::ST_HI;
            end
            tbwp_pkg::ST_HI: begin
                o_cmd.pal = 1'b1;
                n_state   = tbwp_pkg::ST_PAL;
            end
            tbwp_pkg::ST_PAL: begin
                n_state = tbwp_pkg::ST_OUT;
            end
            tbwp_pkg::ST_OUT: begin
                if (i_out_free) begin
                    o_cmd.done = 1'b1;
                    n_state    = tbwp_pkg::ST_IDLE;
                end
            end
            default: n_state = tbwp_pkg::ST_IDLE;
        endcase
    end

endmodule

[rtl/tbwp_dp.sv]
// Datapath: video RAM, palette RAM, address generation and pixel decode.
// Depends on tbwp_pkg.
module tbwp_dp (
    input  logic            i_clk,
    input  tbwp_pkg::t_cmd  i_cmd,
    input  logic [1:0]      i_func,
    input  logic [7:0]      i_row,
    input  logic [7:0]      i_col,
    input  logic [12:0]     i_addr,
    input  logic            i_bank,
    input  logic [7:0]      i_wdata,
    input  logic [7:0]      i_lcdc,
    input  logic [7:0]      i_scy,
    input  logic [7:0]      i_scx,
    input  logic [7:0]      i_wy,
    input  logic [7:0]      i_wx,
    input  logic [7:0]      i_mpal,
    input  logic            i_cmode,
    output tbwp_pkg::t_sts  o_sts,
    output logic [18:0]     o_result
);
    localparam int VramAwL = tbwp_pkg::VramAw;
    localparam int PalAwL  = tbwp_pkg::PalAw;

    logic [7:0] r_vram [0:2*tbwp_pkg::BankBytes-1];
    logic [7:0] r_pal  [0:tbwp_pkg::PaletteBytes-1];

    logic [1:0]  r_func;
    logic        r_quick, r_win;
    logic [12:0] r_entry;
    logic [2:0]  r_fy, r_fx;
    logic [7:0]  r_rd, r_tile, r_attr, r_lo;
    logic [7:0]  r_pd0, r_pd1;
    logic [1:0]  r_cid;

    logic        win, quick;
    logic [7:0]  lx, ly;
    logic [12:0] map_base, entry;
    logic [8:0]  col7;
    logic [7:0]  tidx;
    logic [12:0] tbase;
    logic [3:0]  attr_eff;
    logic [VramAwL-1:0] rd_addr;
    logic        rd_en;
    logic [2:0]  bsel;
    logic [1:0]  cid, shade;
    logic [PalAwL-1:0] pidx;

    // layer selection and map entry address for the incoming item
    always_comb begin
        col7  = {1'b0, i_col} + 9'd7;
        quick = !i_lcdc[7] || !i_lcdc[0] ||
                (i_row >= 8'(tbwp_pkg::ScreenHeight)) ||
                ({1'b0, i_col} >= 9'(tbwp_pkg::ScreenWidth));
        win   = i_lcdc[5] && ({1'b0, i_wy} <= 9'(tbwp_pkg::ScreenHeight - 1)) &&
                ({1'b0, i_wx} <= 9'(tbwp_pkg::ScreenWidth + 6)) &&
                (i_row >= i_wy) && (col7 >= {1'b0, i_wx});
        if (win) begin
            lx       = col7[7:0] - i_wx;
            ly       = i_row - i_wy;
            map_base = i_lcdc[6] ? tbwp_pkg::MAP_HIGH : tbwp_pkg::MAP_LOW;
        end else begin
            lx       = i_col + i_scx;
            ly       = i_row + i_scy;
            map_base = i_lcdc[3] ? tbwp_pkg::MAP_HIGH : tbwp_pkg::MAP_LOW;
        end
        entry = map_base + {3'd0, ly[7:3], lx[7:3]};
    end

    // capture item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_quick <= quick;
            r_win   <= win;
            r_entry <= entry;
            r_fx    <= lx[2:0];
            r_fy    <= ly[2:0];
        end
    end

    // tile row address from tile number
    always_comb begin
        tidx     = i_lcdc[4] ? r_tile : r_tile ^ 8'h80;
        tbase    = (i_lcdc[4] ? 13'h0000 : 13'h0800) + {1'b0, tidx, 4'd0} +
                   {9'd0, r_fy, 1'b0};
        attr_eff = i_cmode ? r_rd[3:0] : 4'd0;
    end

    // single video RAM read port, address by step
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (i_cmd.load && i_func == tbwp_pkg::FUNC_RENDER) begin
            rd_en   = 1'b1;
            rd_addr = {1'b0, entry};
        end else if (i_cmd.rd_attr) begin
            rd_en   = 1'b1;
            rd_addr = {1'b1, r_entry};
        end else if (i_cmd.rd_lo) begin
            rd_en   = 1'b1;
            rd_addr = {attr_eff[3], tbase};
        end else if (i_cmd.rd_hi) begin
            rd_en   = 1'b1;
            rd_addr = {r_attr[3], tbase + 13'd1};
        end
    end

    // video RAM: write on accepted write item, one read a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_func == tbwp_pkg::FUNC_VRAM) begin
            r_vram[{i_bank, i_addr}] <= i_wdata;
        end
        if (rd_en) begin
            r_rd <= r_vram[rd_addr];
        end
    end

    // step results
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_attr) r_tile <= r_rd;
        if (i_cmd.rd_lo)   r_attr <= {4'd0, attr_eff};
        if (i_cmd.rd_hi)   r_lo   <= r_rd;
        if (i_cmd.pal)     r_cid  <= cid;
    end

    // colour number, shade, palette index
    always_comb begin
        bsel  = 3'd7 - r_fx;
        cid   = {r_rd[bsel], r_lo[bsel]};
        shade = i_mpal[2*cid +: 2];
        pidx  = PalAwL'({r_attr[2:0], shade, 1'b0});
    end

    // palette RAM: write on accepted write item, two reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_func == tbwp_pkg::FUNC_PAL &&
            i_addr < 13'(tbwp_pkg::PaletteBytes)) begin
            r_pal[i_addr[PalAwL-1:0]] <= i_wdata;
        end
        if (i_cmd.pal) begin
            r_pd0 <= r_pal[pidx];
            r_pd1 <= r_pal[pidx | PalAwL'(1)];
        end
    end

    logic [1:0] out_shade;
    logic [14:0] color;
    always_comb begin
        out_shade = i_mpal[2*r_cid +: 2];
        color     = i_cmode ? {r_pd1[6:0], r_pd0} : tbwp_pkg::grey(out_shade);
        if (r_quick) begin
            o_result = '0;
        end else begin
            o_result = {r_win, r_cid, color, 1'b1};
        end
        o_sts.is_write = (r_func != tbwp_pkg::FUNC_RENDER);
        o_sts.quick    = r_quick;
    end

endmodule

[rtl/tile_background_window_pixel_top.sv]
// Top level of the tile background and window pixel renderer.
// Depends on tbwp_pkg, tbwp_ctrl and tbwp_dp.
//
// channel  | dir | handshake        | payload
// s_axis   | in  | tvalid / tready  | tdata: func, row, col, address, bank, data
// m_axis   | out | tvalid / tready  | tdata: visible, pixel_color, color_number, window
// apb      | in  | psel/penable     | six 8-bit registers and a 1-bit mode at 4*i
//
// A render reads the map entry, the attribute and two tile bytes through the one
// video RAM port, then the palette RAM; blank pixels skip the fetches. Store
// writes give no result. Reset clears control state; RAM contents are
// undefined until written. A held output stalls the controller.
module tile_background_window_pixel_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // func[1:0] row[9:2] col[17:10] addr[30:18] bank[31] data[39:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // visible[0] color[15:1] number[17:16] window[18]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [7:0] r_lcdc, r_scy, r_scx, r_wy, r_wx, r_mpal;
    logic       r_cmode;
    logic       r_ovalid;
    logic [18:0] r_odata;
    logic [18:0] result;
    tbwp_pkg::t_cmd cmd;
    tbwp_pkg::t_sts sts;
    logic [2:0] ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcdc <= '0; r_scy <= '0; r_scx <= '0; r_wy <= '0;
            r_wx <= '0; r_mpal <= '0; r_cmode <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (ridx)
                tbwp_pkg::REG_LCDC:  r_lcdc  <= pwdata[7:0];
                tbwp_pkg::REG_SCY:   r_scy   <= pwdata[7:0];
                tbwp_pkg::REG_SCX:   r_scx   <= pwdata[7:0];
                tbwp_pkg::REG_WY:    r_wy    <= pwdata[7:0];
                tbwp_pkg::REG_WX:    r_wx    <= pwdata[7:0];
                tbwp_pkg::REG_MPAL:  r_mpal  <= pwdata[7:0];
                tbwp_pkg::REG_CMODE: r_cmode <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        prdata = '0;
        case (ridx)
            tbwp_pkg::REG_LCDC:  prdata = {24'd0, r_lcdc};
            tbwp_pkg::REG_SCY:   prdata = {24'd0, r_scy};
            tbwp_pkg::REG_SCX:   prdata = {24'd0, r_scx};
            tbwp_pkg::REG_WY:    prdata = {24'd0, r_wy};
            tbwp_pkg::REG_WX:    prdata = {24'd0, r_wx};
            tbwp_pkg::REG_MPAL:  prdata = {24'd0, r_mpal};
            tbwp_pkg::REG_CMODE: prdata = {31'd0, r_cmode};
            default:             prdata = '0;
        endcase
    end

    tbwp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (!r_ovalid || m_axis_tready),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    tbwp_dp u_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_func   (s_axis_tdata[1:0]),
        .i_row    (s_axis_tdata[9:2]),
        .i_col    (s_axis_tdata[17:10]),
        .i_addr   (s_axis_tdata[30:18]),
        .i_bank   (s_axis_tdata[31]),
        .i_wdata  (s_axis_tdata[39:32]),
        .i_lcdc   (r_lcdc),
        .i_scy    (r_scy),
        .i_scx    (r_scx),
        .i_wy     (r_wy),
        .i_wx     (r_wx),
        .i_mpal   (r_mpal),
        .i_cmode  (r_cmode),
        .o_sts    (sts),
        .o_result (result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (cmd.done) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.done) r_odata <= result;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_odata};

endmodule

[rtl/tbwp_checker.sv]
// Port checker for the pixel renderer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module tbwp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    `AST_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `AST_NEXT(a_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `AST_NEXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `AST_IMPL(a_blank, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0],
        m_axis_tdata[18:1] == 18'd0)
endmodule

bind tile_background_window_pixel_top tbwp_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[bench/tile_background_window_pixel_top_tb.sv]
// Self-checking testbench for the tile background and window pixel renderer.
// Depends on tbwp_pkg and tile_background_window_pixel_top.
// A scoreboard class models the stores and registers and checks each pixel.
`timescale 1ns / 1ps

module tile_background_window_pixel_top_tb;

    localparam logic [1:0] FUNC_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        bit        vis;
        bit [14:0] color;
        bit [1:0]  num;
        bit        win;
    } t_pix;

    // Pixel scoreboard: shadow stores, registers, and the queue of expected pixels
    class pixel_scoreboard;
        bit [7:0]  vram[2 * tbwp_pkg::BankBytes];
        bit        known[2 * tbwp_pkg::BankBytes];
        bit [7:0]  pram[tbwp_pkg::PaletteBytes];
        bit [7:0]  lcdc, scy, scx, wy, wx, mpal;
        bit        cmode;
        t_pix      pending_pix[$];
        int        errors, mismatches, checked;

        function void set_reg(logic [2:0] idx, bit [7:0] v);
            case (idx)
                tbwp_pkg::REG_LCDC:  lcdc = v;
                tbwp_pkg::REG_SCY:   scy = v;
                tbwp_pkg::REG_SCX:   scx = v;
                tbwp_pkg::REG_WY:    wy = v;
                tbwp_pkg::REG_WX:    wx = v;
                tbwp_pkg::REG_MPAL:  mpal = v;
                tbwp_pkg::REG_CMODE: cmode = v[0];
                default: ;
            endcase
        endfunction

        // Follow the fetch chain of one pixel; returns the first unwritten
        // video RAM address it would touch, or -1 with the pixel worked out.
        function int walk_pixel(int row, int col, output t_pix p);
            bit        win;
            int        map, x, y, entry, tile, attr, base, a0, bitn, idx, shade;
            bit [7:0]  b0, b1;
            bit [1:0]  cid;
            bit [14:0] color;
            p = '{0, 0, 0, 0};
            if (!lcdc[7] || !lcdc[0] || row >= tbwp_pkg::ScreenHeight ||
                col >= tbwp_pkg::ScreenWidth)
                return -1;
            win = lcdc[5] && wy <= tbwp_pkg::ScreenHeight - 1 &&
                  wx <= tbwp_pkg::ScreenWidth + 6 && row >= wy && col + 7 >= wx;
            if (win) begin
                map = lcdc[6] ? int'(tbwp_pkg::MAP_HIGH) : int'(tbwp_pkg::MAP_LOW);
                x = (col + 7 - wx) & 255;
                y = (row - wy) & 255;
            end else begin
                map = lcdc[3] ? int'(tbwp_pkg::MAP_HIGH) : int'(tbwp_pkg::MAP_LOW);
                x = (col + scx) & 255;
                y = (row + scy) & 255;
            end
            entry = map + (y >> 3) * 32 + (x >> 3);
            if (!known[entry]) return entry;
            tile = vram[entry];
            attr = 0;
            if (cmode) begin
                if (!known[tbwp_pkg::BankBytes + entry]) return tbwp_pkg::BankBytes + entry;
                attr = vram[tbwp_pkg::BankBytes + entry];
            end
            // signed tile set is centred on 0x1000
            base = lcdc[4] ? tile * 16 : 'h800 + (tile ^ 'h80) * 16;
            base += (y & 7) * 2;
            a0 = ((attr >> 3) & 1) * tbwp_pkg::BankBytes + base;
            if (!known[a0]) return a0;
            if (!known[a0 + 1]) return a0 + 1;
            b0 = vram[a0];
            b1 = vram[a0 + 1];
            bitn = 7 - (x & 7);
            cid = {b1[bitn], b0[bitn]};
            shade = (mpal >> (2 * cid)) & 3;
            if (cmode) begin
                idx = (attr & 7) * 8 + shade * 2;
                color = {pram[idx + 1][6:0], pram[idx]};
            end else begin
                case (shade)
                    0: color = 15'h7FFF;
                    1: color = 15'h56B5;
                    2: color = 15'h294A;
                    default: color = 15'h0000;
                endcase
            end
            p = '{1, color, cid, win};
            return -1;
        endfunction

        function void note_input(bit [1:0] func, int row, int col, int addr,
                                 bit bank, bit [7:0] data);
            t_pix p;
            int   miss;
            case (func)
                tbwp_pkg::FUNC_VRAM: begin
                    vram[bank * tbwp_pkg::BankBytes + addr] = data;
                    known[bank * tbwp_pkg::BankBytes + addr] = 1;
                end
                tbwp_pkg::FUNC_PAL: if (addr < tbwp_pkg::PaletteBytes) pram[addr] = data;
                tbwp_pkg::FUNC_RENDER: begin
                    miss = walk_pixel(row, col, p);
                    if (miss >= 0) $display("note: render reads unwritten byte %0h", miss);
                    pending_pix.push_back(p);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [23:0] d);
            t_pix e;
            checked++;
            if (pending_pix.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("ERROR: unexpected pixel %h", d);
                return;
            end
            e = pending_pix.pop_front();
            if (d[0] !== e.vis || d[15:1] !== e.color || d[17:16] !== e.num ||
                d[18] !== e.win) begin
                errors++;
                if (mismatches++ < 10)
                    $display({"ERROR: pixel %0d exp vis=%0d col=%h num=%0d win=%0d, ",
                              "got vis=%0d col=%h num=%0d win=%0d"},
                             checked, e.vis, e.color, e.num, e.win,
                             d[0], d[15:1], d[17:16], d[18]);
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    logic [39:0] s_axis_tdata;   // func[1:0] row[9:2] col[17:10] addr[30:18] bank[31] data[39:32]
    logic        m_axis_tvalid, m_axis_tready;
    logic [23:0] m_axis_tdata;   // visible[0] color[15:1] number[17:16] window[18]
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;

    pixel_scoreboard sb = new();
    int  items_sent, settings_used;
    int  idle_cycles = 0;
    bit  hold_done;

    tile_background_window_pixel_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // result capture and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
                (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // receiver back-pressure, with one long hold-off once traffic is flowing
    initial begin
        int r;
        m_axis_tready = 0;
        hold_done = 0;
        forever begin
            @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (!hold_done && sb.checked >= 150) begin
                m_axis_tready = 0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1;
            end else if (r < 60) begin
                m_axis_tready = 1;
            end else if (r < 90) begin
                m_axis_tready = 0;
            end else if (r < 95) begin
                m_axis_tready = 0;
                repeat ($urandom_range(10, 50)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1;
                repeat ($urandom_range(20, 100)) @(negedge i_clk);
            end
        end
    end

    // one input transaction, after a random gap
    task automatic send(bit [1:0] func, bit [7:0] row, bit [7:0] col,
                        bit [12:0] addr, bit bank, bit [7:0] data);
        int r, gap;
        r = $urandom_range(0, 99);
        gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 60);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata = {data, bank, addr, col, row, func};
        s_axis_tvalid = 1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(func, row, col, addr, bank, data);
        items_sent++;
    endtask

    // render a pixel, first writing any video RAM byte it would read unwritten
    task automatic render(bit [7:0] row, bit [7:0] col);
        t_pix p;
        int   miss;
        miss = sb.walk_pixel(row, col, p);
        while (miss >= 0) begin
            send(tbwp_pkg::FUNC_VRAM, 8'($urandom), 8'($urandom),
                 13'(miss % tbwp_pkg::BankBytes), 1'(miss / tbwp_pkg::BankBytes),
                 8'($urandom));
            miss = sb.walk_pixel(row, col, p);
        end
        send(tbwp_pkg::FUNC_RENDER, row, col, 13'($urandom), 1'($urandom), 8'($urandom));
    endtask

    // pause until every pixel is out and the block has settled
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 0;
        while (sb.pending_pix.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] idx, bit [7:0] v);
        @(negedge i_clk);
        psel = 1; pwrite = 1; penable = 0;
        paddr = {idx, 2'b00};
        pwdata = {24'd0, v};
        @(negedge i_clk);
        penable = 1;
        @(posedge i_clk);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel = 0; penable = 0;
    endtask

    task automatic configure(bit [7:0] lcd, bit [7:0] sy, bit [7:0] sx, bit [7:0] y,
                             bit [7:0] x, bit [7:0] mp, bit cm);
        drain();
        apb_write(tbwp_pkg::REG_LCDC, lcd);
        apb_write(tbwp_pkg::REG_SCY, sy);
        apb_write(tbwp_pkg::REG_SCX, sx);
        apb_write(tbwp_pkg::REG_WY, y);
        apb_write(tbwp_pkg::REG_WX, x);
        apb_write(tbwp_pkg::REG_MPAL, mp);
        apb_write(tbwp_pkg::REG_CMODE, {7'd0, cm});
        settings_used++;
    endtask

    // corner and window-edge pixels, then a random mix of items up to the
    // phase's share of input transactions
    task automatic run_phase(int count);
        int r, stop;
        stop = items_sent + count;
        render(0, 0);
        render(143, 159);
        render(144, 0);
        render(0, 160);
        render(255, 255);
        if (sb.wx >= 7) render(sb.wy, 8'(sb.wx - 7));
        if (sb.wx >= 8) render(sb.wy, 8'(sb.wx - 8));
        while (items_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                render(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 143)),
                       ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 159)));
            else if (r < 80)
                send(tbwp_pkg::FUNC_VRAM, 8'($urandom), 8'($urandom),
                     r < 62 ? 13'(13'h1800 + $urandom_range(0, 'h7FF)) : 13'($urandom),
                     1'($urandom), 8'($urandom));
            else if (r < 92)
                send(tbwp_pkg::FUNC_PAL, 8'($urandom), 8'($urandom),
                     r < 89 ? 13'($urandom_range(0, 63)) : 13'($urandom),
                     1'($urandom), 8'($urandom));
            else
                send(FUNC_NOP, 8'($urandom), 8'($urandom), 13'($urandom),
                     1'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        s_axis_tvalid = 0; s_axis_tdata = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        items_sent = 0; settings_used = 0;
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // palette RAM filled so every colour lookup is defined
        for (int a = 0; a < tbwp_pkg::PaletteBytes; a++)
            send(tbwp_pkg::FUNC_PAL, 8'd0, 8'd0, 13'(a), 1'b0,
                 (a == 0) ? 8'h00 : (a == 1) ? 8'hFF : 8'($urandom));
        send(tbwp_pkg::FUNC_VRAM, 8'd0, 8'd0, 13'h1FFF, 1'b1, 8'hFF);
        send(tbwp_pkg::FUNC_VRAM, 8'd0, 8'd0, 13'h0000, 1'b0, 8'h00);

        configure(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
        run_phase(60);
        configure(8'h91, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE4, 0);
        run_phase(80);
        configure(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h1B, 1);
        run_phase(80);
        configure(8'hE9, 8'h80, 8'h7F, 8'd143, 8'd166, 8'hFF, 1);
        run_phase(80);
        configure(8'hA1, 8'h10, 8'h03, 8'd144, 8'd7, 8'h27, 0);
        run_phase(70);
        configure(8'hB1, 8'h55, 8'hAA, 8'd72, 8'd167, 8'h9C, 1);
        run_phase(70);
        configure(8'h7F, 8'h01, 8'h01, 8'h00, 8'h07, 8'hE4, 1);
        run_phase(40);
        for (int k = 0; k < 5; k++) begin
            configure(8'($urandom | 8'h81), 8'($urandom), 8'($urandom),
                      8'($urandom_range(0, 150)), 8'($urandom_range(0, 170)),
                      8'($urandom), 1'($urandom));
            run_phase(100);
        end
        drain();

        $display("summary: %0d input transactions, %0d pixels checked, %0d register settings",
                 items_sent, sb.checked, settings_used);
        if (sb.errors == 0 && sb.pending_pix.size() == 0)
            $display("tb: success");
        else begin
            $display("mismatches: %0d", sb.errors);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
